[rtl/core/button_click_longpress_detector_top_assert.svh]
// assertion macros for the button detector
`ifndef BUTTON_CLICK_LONGPRESS_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_CLICK_LONGPRESS_DETECTOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BCLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`define BCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define BCLD_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define BCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/bcld_pkg.sv]
package bcld_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 8;

    localparam logic [IDX_W-1:0] REG_LONG_PRESS_TIME = 8'd0;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE_TIME   = 8'd1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd750;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;

    typedef struct packed {
        logic click;
        logic long_start;
        logic long_during;
        logic long_stop;
        logic long_pressed;
    } t_result;

endpackage

[rtl/core/bcld_in_if.sv]
interface bcld_in_if;
    import bcld_pkg::*;

    logic              valid;
    logic              ready;
    logic              button_level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink (input valid, input button_level, input now_ms, output ready);
endinterface

[rtl/core/bcld_out_if.sv]
interface bcld_out_if;
    logic valid;
    logic ready;
    logic click;
    logic long_start;
    logic long_during;
    logic long_stop;
    logic long_pressed;

    modport source (
        output valid, output click, output long_start, output long_during,
        output long_stop, output long_pressed, input ready
    );
    modport sink (
        input valid, input click, input long_start, input long_during,
        input long_stop, input long_pressed, output ready
    );
endinterface

[rtl/core/button_click_longpress_detector_top.sv]
// channel   direction  payload
// i_in      in         button_level, now_ms
// o_out     out        click, long_start, long_during, long_stop, long_pressed
// i_cfg_*   in         write enable, register index, 16-bit data
//
// one poll per cycle while o_out.ready is high: the phase update and result
// are computed in the cycle the poll is accepted and registered at that edge
// throughput is one poll per cycle while o_out.ready is
// high, since the phase state updates at the accepting edge
// i_in.ready drops only while a result waits and o_out.ready is low
// synchronous active-low reset returns to idle with default register values
`include "button_click_longpress_detector_top_assert.svh"

module button_click_longpress_detector_top
    import bcld_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bcld_in_if.sink          i_in,
    bcld_out_if.source       o_out
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PRESSED = 2'd1;
    localparam logic [1:0] PH_LONG    = 2'd2;

    logic [CFG_W-1:0]  r_long_press_time;
    logic [CFG_W-1:0]  r_debounce_time;
    logic [1:0]        r_phase;
    logic [1:0]        n_phase;
    logic [TIME_W-1:0] r_press_start;
    logic [TIME_W-1:0] n_press_start;
    logic              r_long_flag;
    logic              n_long_flag;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;
    logic [TIME_W-1:0] elapsed;
    logic              in_fire;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign elapsed    = i_in.now_ms - r_press_start;

    always_comb begin
        n_phase       = r_phase;
        n_press_start = r_press_start;
        n_long_flag   = r_long_flag;
        n_result      = '0;
        case (r_phase)
            PH_PRESSED: begin
                if (i_in.button_level) begin
                    n_result.click = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, r_debounce_time});
                    n_phase        = PH_IDLE;
                end else if (elapsed > {{(TIME_W-CFG_W){1'b0}}, r_long_press_time}) begin
                    n_long_flag          = 1'b1;
                    n_result.long_start  = 1'b1;
                    n_result.long_during = 1'b1;
                    n_phase              = PH_LONG;
                end
            end
            PH_LONG: begin
                if (i_in.button_level) begin
                    n_long_flag        = 1'b0;
                    n_result.long_stop = 1'b1;
                    n_phase            = PH_IDLE;
                end else begin
                    n_result.long_during = 1'b1;
                end
            end
            default: begin
                // idle and the unused code: a low button level starts a press, else idle
                n_phase = PH_IDLE;
                if (!i_in.button_level) begin
                    n_phase       = PH_PRESSED;
                    n_press_start = i_in.now_ms;
                end
            end
        endcase
        n_result.long_pressed = n_long_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_time <= LONG_PRESS_RESET;
            r_debounce_time   <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_LONG_PRESS_TIME) begin
                r_long_press_time <= i_cfg_data;
            end else if (i_cfg_idx == REG_DEBOUNCE_TIME) begin
                r_debounce_time <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_press_start <= '0;
            r_long_flag   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase       <= n_phase;
                r_press_start <= n_press_start;
                r_long_flag   <= n_long_flag;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.click        = r_result.click;
    assign o_out.long_start   = r_result.long_start;
    assign o_out.long_during  = r_result.long_during;
    assign o_out.long_stop    = r_result.long_stop;
    assign o_out.long_pressed = r_result.long_pressed;

    `BCLD_ASSERT_SAME(a_flag_tracks_phase, i_clk, i_rst_n, 1'b1, r_long_flag == (r_phase == PH_LONG))
    `BCLD_ASSERT_SAME(a_one_event, i_clk, i_rst_n, r_out_valid, $onehot0({r_result.click, r_result.long_start, r_result.long_stop}))
    `BCLD_ASSERT_SAME(a_start_implies_during, i_clk, i_rst_n, r_out_valid && r_result.long_start, r_result.long_during && r_result.long_pressed)
    `BCLD_ASSERT_NEXT(a_press_enters_pressed, i_clk, i_rst_n, in_fire && (r_phase == PH_IDLE) && !i_in.button_level, r_phase == PH_PRESSED)
    `BCLD_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, i_in.ready)

endmodule
